### rtl/core/fmva_pkg.sv
// Shared types, codes and tables for the FM voice allocator.
package fmva_pkg;

    // Event command codes
    localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
    localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
    localparam logic [1:0] CMD_BEND     = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // FM register bases
    localparam logic [7:0] ADDR_FNUM_LO = 8'hA0;
    localparam logic [7:0] ADDR_KEYON   = 8'hB0;

    // Key-on flag in the B0 register data
    localparam logic [2:0] KEYON_BITS   = 3'b001;

    // Bend wheel centre
    localparam logic [6:0] BEND_CENTRE  = 7'd64;

    // Request to the frequency number unit
    typedef struct packed {
        logic       start;
        logic [6:0] key;
        logic [6:0] bend;
    } fnum_req_t;

    // Response from the frequency number unit
    typedef struct packed {
        logic       done;
        logic [9:0] fnum;
    } fnum_rsp_t;

    // Semitone frequency number table
    function automatic logic [9:0] semitone(input logic [3:0] idx);
        logic [9:0] val;
        case (idx)
            4'd0:  val = 10'h134;
            4'd1:  val = 10'h146;
            4'd2:  val = 10'h15A;
            4'd3:  val = 10'h16E;
            4'd4:  val = 10'h184;
            4'd5:  val = 10'h19B;
            4'd6:  val = 10'h1B4;
            4'd7:  val = 10'h1CE;
            4'd8:  val = 10'h1E9;
            4'd9:  val = 10'h206;
            4'd10: val = 10'h225;
            4'd11: val = 10'h246;
            4'd12: val = 10'h268;
            4'd13: val = 10'h28D;
            4'd14: val = 10'h2B4;
            4'd15: val = 10'h2DD;
        endcase
        return val;
    endfunction

    // Key divided by twelve, exact for all 7-bit keys (multiply by 43/512)
    function automatic logic [3:0] div12(input logic [6:0] k);
        logic [12:0] p;
        p = 13'(k) * 13'd43;
        return p[12:9];
    endfunction

endpackage

### rtl/core/fmva_fnum_unit.sv
// Multi-cycle frequency number unit: table lookup, bend scaling and divide by 63.
module fmva_fnum_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  fmva_pkg::fnum_req_t req,
    output fmva_pkg::fnum_rsp_t rsp
);
    import fmva_pkg::*;

    // 65536/63 rounded down; one correction step follows
    localparam logic [23:0] RECIP_63 = 24'd1040;

    typedef enum logic [5:0] {
        U_IDLE  = 6'b000001,
        U_LOOK  = 6'b000010,
        U_MUL   = 6'b000100,
        U_RECIP = 6'b001000,
        U_FIX   = 6'b010000,
        U_DONE  = 6'b100000
    } ustate_t;

    ustate_t     state_reg, state_next;
    logic [6:0]  key_reg;
    logic [6:0]  bend_reg;
    logic        down_reg;
    logic [9:0]  base_reg;
    logic [6:0]  span_reg;
    logic [6:0]  dist_reg;
    logic [12:0] prod_reg;
    logic [6:0]  quot_reg;
    logic [9:0]  fnum_reg;

    logic [3:0]  rem12;
    logic [9:0]  base_val;
    logic [9:0]  nb_val;
    logic        down_val;
    logic [23:0] recip_prod;
    logic [12:0] rem63;
    logic [6:0]  quot_fix;

    // Lookup stage arithmetic
    always_comb
    begin
        rem12    = 4'(key_reg - 7'(div12(key_reg) * 4'd12));
        down_val = (bend_reg < BEND_CENTRE);
        base_val = semitone(rem12 + 4'd2);
        nb_val   = down_val ? semitone(rem12) : semitone(rem12 + 4'd4);
    end

    // Reciprocal multiply and remainder correction
    assign recip_prod = 24'(prod_reg) * RECIP_63;
    assign rem63      = prod_reg - ({quot_reg, 6'b0} - 13'(quot_reg));
    assign quot_fix   = (rem63 >= 13'd63) ? quot_reg + 7'd1 : quot_reg;

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE:  if (req.start) state_next = U_LOOK;
            U_LOOK:  state_next = U_MUL;
            U_MUL:   state_next = U_RECIP;
            U_RECIP: state_next = U_FIX;
            U_FIX:   state_next = U_DONE;
            U_DONE:  state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= U_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == U_IDLE && req.start)
        begin
            key_reg  <= req.key;
            bend_reg <= req.bend;
        end
        if (state_reg == U_LOOK)
        begin
            down_reg <= down_val;
            base_reg <= base_val;
            span_reg <= 7'(down_val ? base_val - nb_val : nb_val - base_val);
            dist_reg <= down_val ? BEND_CENTRE - bend_reg : bend_reg - BEND_CENTRE;
        end
        if (state_reg == U_MUL)
            prod_reg <= 13'(dist_reg) * 13'(span_reg);
        if (state_reg == U_RECIP)
            quot_reg <= recip_prod[22:16];
        if (state_reg == U_FIX)
            fnum_reg <= down_reg ? base_reg - 10'(quot_fix) : base_reg + 10'(quot_fix);
    end

    assign rsp.done = (state_reg == U_DONE);
    assign rsp.fnum = fnum_reg;

endmodule

### rtl/core/fm_voice_allocator_pitch_bend.sv
// FM voice allocator with pitch bend, top level.
// Accepts one note-on, note-off or pitch-bend event at a time and answers with FM register
// writes (address, data), the final one of each event flagged by last. The sequencer visits
// the voice slots one per cycle while it passes them over; each voice that needs a new
// frequency number goes through the shared frequency number unit (lookup, multiply,
// reciprocal, correct, done) and then queues its A0 and B0 writes, and every event but an
// unused code ends in a flush state. in_ready is high only between events; an unused
// command code is taken and dropped.
module fm_voice_allocator_pitch_bend #(
    parameter int VOICES = 9
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [6:0] key,
    input  logic [6:0] bend,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] reg_address,
    output logic [7:0] reg_data,
    output logic       last
);
    import fmva_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_CALC   = 6'b000100,
        ST_EMIT_A = 6'b001000,
        ST_EMIT_B = 6'b010000,
        ST_FLUSH  = 6'b100000
    } state_t;

    // Voice slots
    logic        en_reg   [VOICES];
    logic [6:0]  vkey_reg [VOICES];
    logic [2:0]  oct_reg  [VOICES];
    logic [9:0]  fnum_reg [VOICES];

    // Sequencer and event registers
    state_t      state_reg, state_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [6:0]  key_reg, key_next;
    logic [6:0]  bend_reg, bend_next;
    logic [VW-1:0] v_reg, v_next;
    logic        kill_reg, kill_next;
    logic        stop_reg, stop_next;

    // Held beat, released once the next one is known
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_addr_reg, pend_addr_next;
    logic [7:0]  pend_data_reg, pend_data_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_addr_reg, out_addr_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    logic        is_on, is_off, is_refresh;
    logic        rd_en;
    logic [6:0]  rd_key;
    logic        out_free;
    logic        slot_take, slot_clear, fnum_write;
    logic        beat_push;
    logic [7:0]  beat_addr, beat_data;
    logic [7:0]  voice_ofs;
    fnum_req_t   freq;
    fnum_rsp_t   frsp;

    fmva_fnum_unit u_fnum (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (freq),
        .rsp   (frsp)
    );

    // Decode the latched event
    assign is_on      = (cmd_reg == CMD_NOTE_ON) && (key_reg != 7'd0);
    assign is_off     = (cmd_reg == CMD_NOTE_OFF);
    assign is_refresh = ((cmd_reg == CMD_NOTE_ON) && (key_reg == 7'd0)) || (cmd_reg == CMD_BEND);

    assign rd_en     = en_reg[v_reg];
    assign rd_key    = vkey_reg[v_reg];
    assign out_free  = !out_valid_reg || out_ready;
    assign voice_ofs = 8'(v_reg);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        bend_next       = bend_reg;
        v_next          = v_reg;
        kill_next       = kill_reg;
        stop_next       = stop_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_data_next  = pend_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_addr_next   = out_addr_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        freq.start      = 1'b0;
        freq.key        = is_on ? key_reg : rd_key;
        freq.bend       = bend_reg;
        slot_take       = 1'b0;
        slot_clear      = 1'b0;
        fnum_write      = 1'b0;
        beat_push       = 1'b0;
        beat_addr       = ADDR_FNUM_LO | voice_ofs;
        beat_data       = kill_reg ? 8'd0 : fnum_reg[v_reg][7:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next  = command;
                    key_next  = key;
                    v_next    = '0;
                    stop_next = 1'b0;
                    if (command == CMD_BEND)
                        bend_next = bend;
                    if (command != CMD_UNUSED)
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (is_on && (!rd_en || rd_key == key_reg))
                begin
                    slot_take  = 1'b1;
                    freq.start = 1'b1;
                    stop_next  = 1'b1;
                    kill_next  = 1'b0;
                    state_next = ST_CALC;
                end
                else if (is_refresh && rd_en)
                begin
                    freq.start = 1'b1;
                    kill_next  = 1'b0;
                    state_next = ST_CALC;
                end
                else if (is_off && rd_en && rd_key == key_reg)
                begin
                    slot_clear = 1'b1;
                    kill_next  = 1'b1;
                    state_next = ST_EMIT_A;
                end
                else if (v_reg == LAST_VOICE)
                    state_next = ST_FLUSH;
                else
                    v_next = v_reg + 1'b1;
            end
            ST_CALC:
            begin
                if (frsp.done)
                begin
                    fnum_write = 1'b1;
                    state_next = ST_EMIT_A;
                end
            end
            ST_EMIT_A:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    beat_push  = 1'b1;
                    state_next = ST_EMIT_B;
                end
            end
            ST_EMIT_B:
            begin
                beat_addr = ADDR_KEYON | voice_ofs;
                beat_data = kill_reg ? 8'd0
                                     : {KEYON_BITS, oct_reg[v_reg], fnum_reg[v_reg][9:8]};
                if (!pend_valid_reg || out_free)
                begin
                    beat_push = 1'b1;
                    if (stop_reg || v_reg == LAST_VOICE)
                        state_next = ST_FLUSH;
                    else
                    begin
                        v_next     = v_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = pend_addr_reg;
                    out_data_next   = pend_data_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Hold the new beat and release the previous one, not last
        if (beat_push)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_addr_next  = pend_addr_reg;
                out_data_next  = pend_data_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_addr_next  = beat_addr;
            pend_data_next  = beat_data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bend_reg       <= BEND_CENTRE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bend_reg       <= bend_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        v_reg         <= v_next;
        kill_reg      <= kill_next;
        stop_reg      <= stop_next;
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        out_addr_reg  <= out_addr_next;
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
    end

    // Update voice slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                en_reg[i]   <= 1'b0;
                vkey_reg[i] <= 7'd0;
                oct_reg[i]  <= 3'd0;
                fnum_reg[i] <= 10'd0;
            end
        end
        else
        begin
            if (slot_take)
            begin
                en_reg[v_reg]   <= 1'b1;
                vkey_reg[v_reg] <= key_reg;
                oct_reg[v_reg]  <= 3'(div12(key_reg) + 4'd7);
            end
            if (slot_clear)
            begin
                en_reg[v_reg]   <= 1'b0;
                vkey_reg[v_reg] <= 7'd0;
                oct_reg[v_reg]  <= 3'd0;
                fnum_reg[v_reg] <= 10'd0;
            end
            if (fnum_write)
                fnum_reg[v_reg] <= frsp.fnum;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign reg_address = out_addr_reg;
    assign reg_data    = out_data_reg;
    assign last        = out_last_reg;

endmodule

### rtl/core/fmva_checker.sv
// Port-level checker for the FM voice allocator, bound to the top level.
module fmva_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] command,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] reg_address,
    input logic [7:0] reg_data,
    input logic       last
);
    import fmva_pkg::*;

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reg_address)
                                    && $stable(reg_data) && $stable(last))
        else $error("stalled result beat changed");

    // A real event keeps the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command != CMD_UNUSED |=> !in_ready)
        else $error("input taken again right after an event");

    // More beats follow a non-final beat, so no new event yet
    a_mid_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input ready in the middle of an event");

    // Only A0 or B0 registers are written
    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (reg_address[7:4] == ADDR_FNUM_LO[7:4])
                   || (reg_address[7:4] == ADDR_KEYON[7:4]))
        else $error("register address outside A0 and B0 banks");

    // An event always ends on its B0 write
    a_last_b0: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> reg_address[7:4] == ADDR_KEYON[7:4])
        else $error("final beat is not a B0 write");

endmodule

bind fm_voice_allocator_pitch_bend fmva_checker u_fmva_checker (.*);

### sim/tb_fm_voice_allocator_pitch_bend.sv
// Self-checking testbench for the FM voice allocator with pitch bend.
`timescale 1ns / 100ps

module tb_fm_voice_allocator_pitch_bend;
    import fmva_pkg::*;

    localparam int VOICES       = 9;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_BEATS = 80;
    localparam int PHASE_EVENTS = 135;

    // One FM register write as seen on the result channel
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] data;
        logic       last;
    } fm_write_t;

    // Tracks the voice bank and bend wheel, and holds the register writes still due
    class fm_write_tracker;
        fm_write_t  due_writes[$];
        bit         on_voice[VOICES];
        logic [6:0] held_key[VOICES];
        logic [2:0] held_oct[VOICES];
        logic [9:0] held_fnum[VOICES];
        logic [6:0] wheel;
        int         semis[16] = '{'h134, 'h146, 'h15A, 'h16E, 'h184, 'h19B, 'h1B4, 'h1CE,
                                  'h1E9, 'h206, 'h225, 'h246, 'h268, 'h28D, 'h2B4, 'h2DD};
        int         mismatches;
        int         writes_checked;
        int         events_by_cmd[4];

        function new();
            for (int v = 0; v < VOICES; v++)
            begin
                on_voice[v]  = 1'b0;
                held_key[v]  = '0;
                held_oct[v]  = '0;
                held_fnum[v] = '0;
            end
            wheel          = BEND_CENTRE;
            mismatches     = 0;
            writes_checked = 0;
            foreach (events_by_cmd[i])
                events_by_cmd[i] = 0;
        endfunction

        // Interpolate toward the entry two semitones away, scaled by wheel offset / 63
        function logic [9:0] bent_fnum(logic [6:0] k, logic [6:0] w);
            int idx;
            int base;
            int r;
            idx  = int'(k) % 12 + 2;
            base = semis[idx];
            if (w < BEND_CENTRE)
                r = base - ((64 - int'(w)) * (base - semis[idx - 2])) / 63;
            else
                r = base + ((int'(w) - 64) * (semis[idx + 2] - base)) / 63;
            return 10'(r);
        endfunction

        // Queue the A0/B0 pair for one voice
        function void queue_voice(int v);
            fm_write_t wr;
            wr.addr = ADDR_FNUM_LO + 8'(v);
            wr.data = held_fnum[v][7:0];
            wr.last = 1'b0;
            due_writes.push_back(wr);
            wr.addr = ADDR_KEYON + 8'(v);
            wr.data = {KEYON_BITS, held_oct[v], held_fnum[v][9:8]};
            due_writes.push_back(wr);
        endfunction

        // Recompute every enabled voice at the current wheel position
        function void refresh_voices();
            for (int v = 0; v < VOICES; v++)
            begin
                if (on_voice[v])
                begin
                    held_fnum[v] = bent_fnum(held_key[v], wheel);
                    queue_voice(v);
                end
            end
        endfunction

        // Note one accepted event and queue the writes it causes
        function void take_event(logic [1:0] cmd, logic [6:0] k, logic [6:0] w);
            int        n_prior;
            int        slot;
            fm_write_t wr;
            n_prior = due_writes.size();
            slot    = -1;
            events_by_cmd[cmd]++;
            case (cmd)
                CMD_NOTE_ON:
                begin
                    if (k == 7'd0)
                        refresh_voices();
                    else
                    begin
                        for (int v = 0; v < VOICES; v++)
                            if (slot < 0 && (!on_voice[v] || held_key[v] == k))
                                slot = v;
                        if (slot >= 0)
                        begin
                            on_voice[slot]  = 1'b1;
                            held_key[slot]  = k;
                            held_oct[slot]  = 3'((int'(k) / 12 + 7) % 8);
                            held_fnum[slot] = bent_fnum(k, wheel);
                            queue_voice(slot);
                        end
                    end
                end
                CMD_NOTE_OFF:
                begin
                    for (int v = 0; v < VOICES; v++)
                    begin
                        if (on_voice[v] && held_key[v] == k)
                        begin
                            wr.addr = ADDR_FNUM_LO + 8'(v);
                            wr.data = '0;
                            wr.last = 1'b0;
                            due_writes.push_back(wr);
                            wr.addr = ADDR_KEYON + 8'(v);
                            due_writes.push_back(wr);
                            on_voice[v]  = 1'b0;
                            held_key[v]  = '0;
                            held_oct[v]  = '0;
                            held_fnum[v] = '0;
                        end
                    end
                end
                CMD_BEND:
                begin
                    wheel = w;
                    refresh_voices();
                end
                default:
                begin
                end
            endcase
            // Flag the final write of this event
            if (due_writes.size() > n_prior)
                due_writes[due_writes.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Compare one accepted write against the oldest one due
        task check_write(logic [7:0] a, logic [7:0] d, logic l);
            fm_write_t exp_wr;
            writes_checked++;
            if (due_writes.size() == 0)
                report($sformatf("write %h <= %h with nothing due", a, d));
            else
            begin
                exp_wr = due_writes.pop_front();
                if (a !== exp_wr.addr)
                    report($sformatf("reg_address %h, expected %h", a, exp_wr.addr));
                if (d !== exp_wr.data)
                    report($sformatf("reg_data %h at %h, expected %h", d, exp_wr.addr,
                                     exp_wr.data));
                if (l !== exp_wr.last)
                    report($sformatf("last %b at %h, expected %b", l, exp_wr.addr,
                                     exp_wr.last));
            end
        endtask
    endclass

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] command   = CMD_NOTE_ON;
    logic [6:0] key       = '0;
    logic [6:0] bend      = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] reg_address;
    logic [7:0] reg_data;
    logic       last;

    fm_write_tracker bank = new();
    int              in_idle_pct  = 0;
    int              out_idle_pct = 0;
    int              cycles       = 0;
    logic [6:0]      key_pool[12];

    fm_voice_allocator_pitch_bend #(
        .VOICES(VOICES)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .key        (key),
        .bend       (bend),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reg_address(reg_address),
        .reg_data   (reg_data),
        .last       (last)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Stall the result channel at random
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);

    // Check every accepted write beat
    always @(posedge clk)
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            bank.check_write(reg_address, reg_data, last);

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one event, idling first at random, and hold it until accepted
    task send_event(logic [1:0] cmd, logic [6:0] k, logic [6:0] w);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        bend     <= w;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        bank.take_event(cmd, k, w);
    endtask

    // Hold off the sender until every due write has come, then let the block go quiet
    task drain_writes();
        in_valid <= 1'b0;
        while (bank.due_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_BEATS) @(posedge clk);
    endtask

    // Random events, mostly over a small key pool so voices fill up and note-offs hit
    task random_events(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_event(CMD_NOTE_ON, key_pool[$urandom_range(0, 11)], 7'($urandom));
            else if (pick < 70)
                send_event(CMD_NOTE_OFF, key_pool[$urandom_range(0, 11)], 7'($urandom));
            else if (pick < 80)
                send_event(CMD_BEND, 7'($urandom), 7'($urandom_range(0, 127)));
            else if (pick < 85)
                send_event(CMD_NOTE_ON, 7'd0, 7'($urandom));
            else if (pick < 90)
                send_event(CMD_NOTE_ON, 7'($urandom_range(0, 127)), 7'($urandom));
            else if (pick < 95)
                send_event(CMD_NOTE_OFF, 7'($urandom_range(0, 127)), 7'($urandom));
            else
                send_event(CMD_UNUSED, 7'($urandom), 7'($urandom));
        end
    endtask

    initial
    begin
        foreach (key_pool[i])
            key_pool[i] = 7'($urandom_range(1, 127));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles lightly, receiver stalls heavily
        in_idle_pct  = 34;
        out_idle_pct = 74;

        // Refresh and note-off on an empty bank, unused code
        send_event(CMD_NOTE_ON, 7'd0, 7'd127);
        send_event(CMD_NOTE_OFF, 7'd60, 7'd0);
        send_event(CMD_UNUSED, 7'd127, 7'd127);
        // Lowest keys take octave 7 and key 12 wraps to octave 0, then key extremes and a repeated key
        send_event(CMD_NOTE_ON, 7'd1, 7'd0);
        send_event(CMD_NOTE_ON, 7'd11, 7'd85);
        send_event(CMD_NOTE_ON, 7'd12, 7'd42);
        send_event(CMD_NOTE_ON, 7'd127, 7'd127);
        send_event(CMD_NOTE_ON, 7'd127, 7'd0);
        // Wheel extremes and just below centre
        send_event(CMD_BEND, 7'd0, 7'd0);
        send_event(CMD_BEND, 7'd127, 7'd127);
        send_event(CMD_BEND, 7'd64, 7'd63);
        // Fill the bank, then overflow it
        send_event(CMD_NOTE_ON, 7'd60, 7'd1);
        send_event(CMD_NOTE_ON, 7'd61, 7'd2);
        send_event(CMD_NOTE_ON, 7'd62, 7'd4);
        send_event(CMD_NOTE_ON, 7'd63, 7'd8);
        send_event(CMD_NOTE_ON, 7'd64, 7'd16);
        send_event(CMD_NOTE_ON, 7'd100, 7'd32);
        // Full refresh, key-zero note-off, reuse of a freed slot
        send_event(CMD_NOTE_ON, 7'd0, 7'd0);
        send_event(CMD_NOTE_OFF, 7'd0, 7'd127);
        send_event(CMD_NOTE_OFF, 7'd11, 7'd0);
        send_event(CMD_NOTE_ON, 7'd100, 7'd0);
        send_event(CMD_BEND, 7'd0, 7'd64);
        send_event(CMD_NOTE_OFF, 7'd127, 7'd0);
        send_event(CMD_NOTE_OFF, 7'd1, 7'd0);

        random_events(PHASE_EVENTS);
        drain_writes();

        // Sender idles heavily, receiver stalls lightly
        in_idle_pct  = 74;
        out_idle_pct = 34;
        random_events(PHASE_EVENTS);
        drain_writes();

        // Back-to-back on both sides
        in_idle_pct  = 0;
        out_idle_pct = 0;
        random_events(PHASE_EVENTS);
        drain_writes();

        if (bank.due_writes.size() != 0)
            bank.report($sformatf("%0d writes never arrived", bank.due_writes.size()));

        $display("Covered %0d events: %0d note-on, %0d note-off, %0d bend, %0d unused code",
                 bank.events_by_cmd[0] + bank.events_by_cmd[1] + bank.events_by_cmd[2]
                 + bank.events_by_cmd[3], bank.events_by_cmd[CMD_NOTE_ON],
                 bank.events_by_cmd[CMD_NOTE_OFF], bank.events_by_cmd[CMD_BEND],
                 bank.events_by_cmd[CMD_UNUSED]);
        $display("Compared %0d register writes under three pacing mixes, %0d mismatches",
                 bank.writes_checked, bank.mismatches);

        if (bank.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
